// ===== sv/svdpp_pkg.sv =====
// Shared types, codes and saturation helpers of the SVD++ factor engine.
package svdpp_pkg;

  localparam int QW   = 32;   // Q8.24 word
  localparam int SW   = 50;   // wide signed sum width
  localparam int PW   = 42;   // product register width
  localparam int BW   = 33;   // second multiplier operand width
  localparam int INVW = 25;   // Q0.24 inverse square root, up to 1.0

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [SW-1:0] wide_t;

  localparam wide_t QMAX_W = 50'sd2147483647;
  localparam wide_t QMIN_W = -50'sd2147483648;

  localparam logic [2:0] CMD_PREDICT  = 3'd0;
  localparam logic [2:0] CMD_BEGIN    = 3'd1;
  localparam logic [2:0] CMD_IMPLICIT = 3'd2;
  localparam logic [2:0] CMD_TRAIN    = 3'd3;
  localparam logic [2:0] CMD_UPDATE   = 3'd4;
  localparam logic [2:0] CMD_LOAD_U   = 3'd5;
  localparam logic [2:0] CMD_LOAD_I   = 3'd6;
  localparam logic [2:0] CMD_SPARE    = 3'd7;

  localparam logic [2:0] REG_MEAN     = 3'd0;
  localparam logic [2:0] REG_BRATE    = 3'd1;
  localparam logic [2:0] REG_BDECAY   = 3'd2;
  localparam logic [2:0] REG_FRATE    = 3'd3;
  localparam logic [2:0] REG_FDECAY   = 3'd4;
  localparam logic [2:0] REG_IRATE    = 3'd5;
  localparam logic [2:0] REG_IDECAY   = 3'd6;
  localparam logic [2:0] REG_NONE     = 3'd7;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic q_t sat32(input wide_t v);
    q_t r;
    if (v > QMAX_W) begin
      r = q_t'(QMAX_W);
    end else if (v < QMIN_W) begin
      r = q_t'(QMIN_W);
    end else begin
      r = q_t'(v);
    end
    return r;
  endfunction

  function automatic wide_t wq(input q_t v);
    return wide_t'(v);
  endfunction

endpackage

// ===== sv/svdpp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module svdpp_ram #(
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata_r
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== sv/svdpp_isqrt.sv =====
// Bit-serial inverse square root: floor(2^24 / sqrt(n)), each result bit found by a square phase and a test phase.
module svdpp_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [15:0]                 n,
  output logic                        busy,
  output logic [svdpp_pkg::INVW-1:0]  root
);
  import svdpp_pkg::*;

  typedef enum logic {PH_SQ, PH_TEST} ph_t;

  localparam logic [INVW-1:0] ONE_Q = INVW'(1) << 24;
  localparam logic [65:0]     LIM   = 66'(1) << 48;

  ph_t              ph_r, ph_nxt;
  logic             busy_r, busy_nxt;
  logic [INVW-1:0]  r_r, r_nxt;
  logic [4:0]       bit_r, bit_nxt;
  logic [49:0]      sq_r, sq_nxt;
  logic [15:0]      n_r, n_nxt;
  logic [INVW-1:0]  cand;
  logic [65:0]      scaled;

  assign cand   = r_r | (INVW'(1) << bit_r);
  assign scaled = 66'(sq_r) * 66'(n_r);
  assign busy   = busy_r;
  assign root   = r_r;

  always_comb begin
    ph_nxt   = ph_r;
    busy_nxt = busy_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    sq_nxt   = sq_r;
    n_nxt    = n_r;
    if (start) begin
      busy_nxt = 1'b1;
      r_nxt    = '0;
      bit_nxt  = 5'd24;
      ph_nxt   = PH_SQ;
      n_nxt    = (n == 16'd0) ? 16'd1 : n;
    end else if (busy_r) begin
      unique case (ph_r)
        PH_SQ: begin
          sq_nxt = 50'(cand) * 50'(cand);
          ph_nxt = PH_TEST;
        end
        PH_TEST: begin
          if (cand <= ONE_Q && scaled <= LIM) begin
            r_nxt = cand;
          end
          if (bit_r == 5'd0) begin
            busy_nxt = 1'b0;
          end else begin
            bit_nxt = bit_r - 5'd1;
          end
          ph_nxt = PH_SQ;
        end
        default: ph_nxt = PH_SQ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_SQ;
      busy_r <= 1'b0;
      r_r    <= '0;
      bit_r  <= '0;
    end else begin
      ph_r   <= ph_nxt;
      busy_r <= busy_nxt;
      r_r    <= r_nxt;
      bit_r  <= bit_nxt;
    end
    sq_r <= sq_nxt;
    n_r  <= n_nxt;
  end

endmodule

// ===== sv/svdpp_factor_sgd_engine.sv =====
// Top level of the SVD++ factor engine: sequencer, shared multiplier and state memories.
//
// The engine takes one command at a time: a transfer happens at a clock edge with start
// high and busy low, and busy stays high until the result is out. Every command first forms
// the estimate mean + user bias + item bias + sum over factors of (p + implicit sum) * q,
// then performs its action, and finally shows estimate and error for exactly one cycle with
// out_valid high; the receiver cannot stall, so it must take the result in that cycle. All
// products of the sequencer go through one multiplier with a register at its output, stepped
// by a small sequencer. A command with a user or item index outside the tables skips the
// estimate and the action and returns zeros. A separate bit-serial unit forms
// 1/sqrt(implicit_count) alongside the estimate. After reset the block first sweeps the
// bias, implicit factor, implicit sum and error accumulator memories to zero, one address
// per cycle over the largest of them (2^15 addresses at the default size); busy is high
// during that sweep, while configuration writes are taken at any time. Configuration
// should only be written while the block is idle.
module svdpp_factor_sgd_engine #(
  parameter int NUM_USERS = 1024,
  parameter int NUM_ITEMS = 1024,
  parameter int FACTORS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_command,
  input  logic [9:0]            in_user_index,
  input  logic [9:0]            in_item_index,
  input  logic [2:0]            in_rating,
  input  logic [15:0]           in_implicit_count,
  input  logic [15:0]           in_explicit_count,
  input  logic [5:0]            in_factor_slot,
  input  logic signed [31:0]    in_load_value,
  output logic                  out_valid,
  output logic signed [31:0]    out_estimate,
  output logic signed [31:0]    out_error,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_index,
  input  logic [26:0]           cfg_wdata
);
  import svdpp_pkg::*;

  localparam int UW  = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
  localparam int IW  = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
  localparam int FW  = (FACTORS > 1) ? $clog2(FACTORS) : 1;
  localparam int UFW = UW + FW;
  localparam int IFW = IW + FW;
  localparam int CW  = (UFW > IFW) ? UFW : IFW;
  localparam logic [FW-1:0] LAST_L = FW'(FACTORS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EST, S_SUM, S_ERR, S_DISP, S_BEGIN, S_IMPL,
    S_BIAS, S_TRAIN, S_W, S_UPD, S_RESP
  } state_t;

  // Configuration registers.
  logic [26:0] mean_r;
  logic [23:0] brate_r, bdecay_r, frate_r, fdecay_r, irate_r, idecay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r   <= 27'd60557633;
      brate_r  <= 24'd117441;
      bdecay_r <= 24'd83886;
      frate_r  <= 24'd117441;
      fdecay_r <= 24'd251658;
      irate_r  <= 24'd117441;
      idecay_r <= 24'd251658;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MEAN:   mean_r   <= cfg_wdata;
        REG_BRATE:  brate_r  <= cfg_wdata[23:0];
        REG_BDECAY: bdecay_r <= cfg_wdata[23:0];
        REG_FRATE:  frate_r  <= cfg_wdata[23:0];
        REG_FDECAY: fdecay_r <= cfg_wdata[23:0];
        REG_IRATE:  irate_r  <= cfg_wdata[23:0];
        REG_IDECAY: idecay_r <= cfg_wdata[23:0];
        REG_NONE:   ;
        default:    ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  state_t          state_r, state_nxt;
  logic [3:0]      st_r, st_nxt;
  logic [FW-1:0]   l_r, l_nxt;
  logic [CW-1:0]   clr_r, clr_nxt;
  logic [2:0]      cmd_r, cmd_nxt;
  logic [UW-1:0]   u_r, u_nxt;
  logic [IW-1:0]   m_r, m_nxt;
  logic [2:0]      rating_r, rating_nxt;
  logic [15:0]     ecount_r, ecount_nxt;
  logic [5:0]      slot_r, slot_nxt;
  q_t              load_r, load_nxt;
  wide_t           dot_r, dot_nxt;
  q_t              est_r, est_nxt, err_r, err_nxt;
  q_t              p_r, p_nxt, q_r, q_nxt, s_r, s_nxt, y_r, y_nxt, a_r, a_nxt;
  q_t              tmp_r, tmp_nxt, w_r, w_nxt;
  logic signed [PW-1:0] t1_r, t1_nxt, prod_r;
  logic            out_valid_r, out_valid_nxt;
  q_t              out_est_r, out_est_nxt, out_err_r, out_err_nxt;

  // Shared multiplier: Q.24 product rounded half up, or the plain integer product.
  logic signed [PW-1:0]     mul_a;
  logic signed [BW-1:0]     mul_b;
  logic                     mul_raw;
  logic signed [PW+BW-1:0]  mfull, mrnd;

  assign mfull = (PW+BW)'(mul_a) * (PW+BW)'(mul_b);
  assign mrnd  = (mfull + (PW+BW)'(25'sh0800000)) >>> 24;

  always_ff @(posedge clk) begin
    prod_r <= mul_raw ? mfull[PW-1:0] : mrnd[PW-1:0];
  end

  // Inverse square root of the implicit count.
  logic             isq_start, isq_busy;
  logic [INVW-1:0]  inv;

  svdpp_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (isq_start),
    .n     (in_implicit_count),
    .busy  (isq_busy),
    .root  (inv)
  );

  // State memories.
  logic            ub_we, ib_we, uf_we, if_we, y_we, sm_we, acc_we;
  logic [UW-1:0]   ub_wa;
  logic [IW-1:0]   ib_wa;
  logic [UFW-1:0]  uf_wa, sm_wa;
  logic [IFW-1:0]  if_wa, y_wa;
  logic [FW-1:0]   acc_wa;
  q_t              ub_wd, ib_wd, uf_wd, if_wd, y_wd, sm_wd, acc_wd;
  q_t              ub_rd, ib_rd, uf_rd, if_rd, y_rd, sm_rd, acc_rd;
  logic [UFW-1:0]  urow;
  logic [IFW-1:0]  irow;

  assign urow = {u_r, l_r};
  assign irow = {m_r, l_r};

  svdpp_ram #(.WIDTH(QW), .ADDR_W(UW)) u_ub_ram (
    .clk(clk), .we(ub_we), .waddr(ub_wa), .wdata(ub_wd), .raddr(u_r), .rdata_r(ub_rd));
  svdpp_ram #(.WIDTH(QW), .ADDR_W(IW)) u_ib_ram (
    .clk(clk), .we(ib_we), .waddr(ib_wa), .wdata(ib_wd), .raddr(m_r), .rdata_r(ib_rd));
  svdpp_ram #(.WIDTH(QW), .ADDR_W(UFW)) u_uf_ram (
    .clk(clk), .we(uf_we), .waddr(uf_wa), .wdata(uf_wd), .raddr(urow), .rdata_r(uf_rd));
  svdpp_ram #(.WIDTH(QW), .ADDR_W(IFW)) u_if_ram (
    .clk(clk), .we(if_we), .waddr(if_wa), .wdata(if_wd), .raddr(irow), .rdata_r(if_rd));
  svdpp_ram #(.WIDTH(QW), .ADDR_W(IFW)) u_y_ram (
    .clk(clk), .we(y_we), .waddr(y_wa), .wdata(y_wd), .raddr(irow), .rdata_r(y_rd));
  svdpp_ram #(.WIDTH(QW), .ADDR_W(UFW)) u_sm_ram (
    .clk(clk), .we(sm_we), .waddr(sm_wa), .wdata(sm_wd), .raddr(urow), .rdata_r(sm_rd));
  svdpp_ram #(.WIDTH(QW), .ADDR_W(FW)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_wa), .wdata(acc_wd), .raddr(l_r), .rdata_r(acc_rd));

  logic in_range;
  assign in_range = (32'(in_user_index) < 32'(NUM_USERS)) &&
                    (32'(in_item_index) < 32'(NUM_ITEMS));

  assign isq_start = (state_r == S_IDLE) && start && in_range;
  assign busy      = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_estimate = out_est_r;
  assign out_error    = out_err_r;

  always_comb begin
    state_nxt  = state_r;
    st_nxt     = st_r;
    l_nxt      = l_r;
    clr_nxt    = clr_r;
    cmd_nxt    = cmd_r;
    u_nxt      = u_r;
    m_nxt      = m_r;
    rating_nxt = rating_r;
    ecount_nxt = ecount_r;
    slot_nxt   = slot_r;
    load_nxt   = load_r;
    dot_nxt    = dot_r;
    est_nxt    = est_r;
    err_nxt    = err_r;
    p_nxt      = p_r;
    q_nxt      = q_r;
    s_nxt      = s_r;
    y_nxt      = y_r;
    a_nxt      = a_r;
    tmp_nxt    = tmp_r;
    w_nxt      = w_r;
    t1_nxt     = t1_r;
    out_valid_nxt = 1'b0;
    out_est_nxt   = out_est_r;
    out_err_nxt   = out_err_r;
    mul_a   = '0;
    mul_b   = '0;
    mul_raw = 1'b0;
    ub_we = 1'b0; ub_wa = u_r;  ub_wd = '0;
    ib_we = 1'b0; ib_wa = m_r;  ib_wd = '0;
    uf_we = 1'b0; uf_wa = urow; uf_wd = '0;
    if_we = 1'b0; if_wa = irow; if_wd = '0;
    y_we  = 1'b0; y_wa  = irow; y_wd  = '0;
    sm_we = 1'b0; sm_wa = urow; sm_wd = '0;
    acc_we = 1'b0; acc_wa = l_r; acc_wd = '0;

    unique case (state_r)
      S_CLEAR: begin
        ub_we = 1'b1;  ub_wa  = clr_r[UW-1:0];
        ib_we = 1'b1;  ib_wa  = clr_r[IW-1:0];
        y_we  = 1'b1;  y_wa   = clr_r[IFW-1:0];
        sm_we = 1'b1;  sm_wa  = clr_r[UFW-1:0];
        acc_we = 1'b1; acc_wa = clr_r[FW-1:0];
        clr_nxt = clr_r + CW'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_command;
          u_nxt      = UW'(in_user_index);
          m_nxt      = IW'(in_item_index);
          rating_nxt = in_rating;
          ecount_nxt = in_explicit_count;
          slot_nxt   = in_factor_slot;
          load_nxt   = in_load_value;
          l_nxt      = '0;
          st_nxt     = '0;
          dot_nxt    = '0;
          if (in_range) begin
            state_nxt = S_EST;
          end else begin
            est_nxt   = '0;
            err_nxt   = '0;
            state_nxt = S_RESP;
          end
        end
      end
      S_EST: begin
        unique case (st_r)
          4'd0: st_nxt = 4'd1;
          4'd1: begin
            tmp_nxt = sat32(wq(uf_rd) + wq(sm_rd));
            st_nxt  = 4'd2;
          end
          4'd2: begin
            mul_a  = PW'(tmp_r);
            mul_b  = BW'(if_rd);
            st_nxt = 4'd3;
          end
          default: begin
            dot_nxt = dot_r + wide_t'(prod_r);
            st_nxt  = '0;
            if (l_r == LAST_L) begin
              l_nxt     = '0;
              state_nxt = S_SUM;
            end else begin
              l_nxt = l_r + FW'(1);
            end
          end
        endcase
      end
      S_SUM: begin
        est_nxt   = sat32($signed({23'b0, mean_r}) + wq(ub_rd) + wq(ib_rd) + dot_r);
        state_nxt = S_ERR;
      end
      S_ERR: begin
        if (cmd_r == CMD_TRAIN) begin
          err_nxt = sat32($signed({23'b0, rating_r, 24'b0}) - wq(est_r));
        end else begin
          err_nxt = '0;
        end
        state_nxt = S_DISP;
      end
      S_DISP: begin
        st_nxt = '0;
        l_nxt  = '0;
        if (!isq_busy) begin
          unique case (cmd_r)
            CMD_BEGIN:    state_nxt = S_BEGIN;
            CMD_IMPLICIT: state_nxt = S_IMPL;
            CMD_TRAIN:    state_nxt = S_BIAS;
            CMD_UPDATE:   state_nxt = S_W;
            CMD_LOAD_U: begin
              if (32'(slot_r) < 32'(FACTORS)) begin
                uf_we = 1'b1;
                uf_wa = {u_r, slot_r[FW-1:0]};
                uf_wd = load_r;
              end
              state_nxt = S_RESP;
            end
            CMD_LOAD_I: begin
              if (32'(slot_r) < 32'(FACTORS)) begin
                if_we = 1'b1;
                if_wa = {m_r, slot_r[FW-1:0]};
                if_wd = load_r;
              end
              state_nxt = S_RESP;
            end
            CMD_PREDICT, CMD_SPARE: state_nxt = S_RESP;
            default:                state_nxt = S_RESP;
          endcase
        end
      end
      S_BEGIN: begin
        sm_we  = 1'b1;
        acc_we = 1'b1;
        if (l_r == LAST_L) begin
          state_nxt = S_RESP;
        end else begin
          l_nxt = l_r + FW'(1);
        end
      end
      S_IMPL: begin
        unique case (st_r)
          4'd0: st_nxt = 4'd1;
          4'd1: begin
            s_nxt  = sm_rd;
            mul_a  = PW'(y_rd);
            mul_b  = BW'({1'b0, inv});
            st_nxt = 4'd2;
          end
          default: begin
            sm_we  = 1'b1;
            sm_wd  = sat32(wq(s_r) + wide_t'(prod_r));
            st_nxt = '0;
            if (l_r == LAST_L) begin
              state_nxt = S_RESP;
            end else begin
              l_nxt = l_r + FW'(1);
            end
          end
        endcase
      end
      S_BIAS: begin
        // Steps 0..3 update the user bias, steps 4..7 the item bias.
        unique case (st_r)
          4'd0, 4'd4: begin
            mul_a  = $signed({18'b0, bdecay_r});
            mul_b  = (st_r == 4'd0) ? BW'(ub_rd) : BW'(ib_rd);
            st_nxt = st_r + 4'd1;
          end
          4'd1, 4'd5: begin
            tmp_nxt = sat32(wq(err_r) - wide_t'(prod_r));
            st_nxt  = st_r + 4'd1;
          end
          4'd2, 4'd6: begin
            mul_a  = $signed({18'b0, brate_r});
            mul_b  = BW'(tmp_r);
            st_nxt = st_r + 4'd1;
          end
          4'd3: begin
            ub_we  = 1'b1;
            ub_wd  = sat32(wq(ub_rd) + wide_t'(prod_r));
            st_nxt = 4'd4;
          end
          default: begin
            ib_we     = 1'b1;
            ib_wd     = sat32(wq(ib_rd) + wide_t'(prod_r));
            st_nxt    = '0;
            state_nxt = S_TRAIN;
          end
        endcase
      end
      S_TRAIN: begin
        st_nxt = st_r + 4'd1;
        unique case (st_r)
          4'd0: ;
          4'd1: begin
            p_nxt = uf_rd;
            q_nxt = if_rd;
            s_nxt = sm_rd;
            a_nxt = acc_rd;
            mul_a = PW'(err_r);
            mul_b = BW'(if_rd);
          end
          4'd2: begin
            t1_nxt = prod_r;
            mul_a  = $signed({18'b0, fdecay_r});
            mul_b  = BW'(p_r);
          end
          4'd3: tmp_nxt = sat32(wide_t'(t1_r) - wide_t'(prod_r));
          4'd4: begin
            mul_a = $signed({18'b0, frate_r});
            mul_b = BW'(tmp_r);
          end
          4'd5: p_nxt = sat32(wq(p_r) + wide_t'(prod_r));
          4'd6: tmp_nxt = sat32(wq(p_r) + wq(s_r));
          4'd7: begin
            mul_a = PW'(err_r);
            mul_b = BW'(tmp_r);
          end
          4'd8: begin
            t1_nxt = prod_r;
            mul_a  = $signed({18'b0, fdecay_r});
            mul_b  = BW'(q_r);
          end
          4'd9: tmp_nxt = sat32(wide_t'(t1_r) - wide_t'(prod_r));
          4'd10: begin
            mul_a = $signed({18'b0, frate_r});
            mul_b = BW'(tmp_r);
          end
          4'd11: q_nxt = sat32(wq(q_r) + wide_t'(prod_r));
          4'd12: begin
            mul_a = PW'(err_r);
            mul_b = BW'(q_r);
          end
          4'd13: begin
            mul_a = prod_r;
            mul_b = BW'({1'b0, inv});
          end
          default: begin
            uf_we  = 1'b1;
            uf_wd  = p_r;
            if_we  = 1'b1;
            if_wd  = q_r;
            acc_we = 1'b1;
            acc_wd = sat32(wq(a_r) + wide_t'(prod_r));
            st_nxt = '0;
            if (l_r == LAST_L) begin
              state_nxt = S_RESP;
            end else begin
              l_nxt = l_r + FW'(1);
            end
          end
        endcase
      end
      S_W: begin
        if (st_r == 4'd0) begin
          mul_raw = 1'b1;
          mul_a   = $signed({18'b0, idecay_r});
          mul_b   = $signed({17'b0, ecount_r});
          st_nxt  = 4'd1;
        end else begin
          w_nxt     = sat32(wide_t'(prod_r));
          st_nxt    = '0;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        st_nxt = st_r + 4'd1;
        unique case (st_r)
          4'd0: ;
          4'd1: begin
            y_nxt = y_rd;
            a_nxt = acc_rd;
            mul_a = PW'(w_r);
            mul_b = BW'(y_rd);
          end
          4'd2: tmp_nxt = sat32(wq(a_r) - wide_t'(prod_r));
          4'd3: begin
            mul_a = $signed({18'b0, irate_r});
            mul_b = BW'(tmp_r);
          end
          default: begin
            y_we   = 1'b1;
            y_wd   = sat32(wq(y_r) + wide_t'(prod_r));
            st_nxt = '0;
            if (l_r == LAST_L) begin
              state_nxt = S_RESP;
            end else begin
              l_nxt = l_r + FW'(1);
            end
          end
        endcase
      end
      S_RESP: begin
        out_valid_nxt = 1'b1;
        out_est_nxt   = est_r;
        out_err_nxt   = err_r;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      st_r        <= '0;
      l_r         <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      l_r         <= l_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r     <= cmd_nxt;
    u_r       <= u_nxt;
    m_r       <= m_nxt;
    rating_r  <= rating_nxt;
    ecount_r  <= ecount_nxt;
    slot_r    <= slot_nxt;
    load_r    <= load_nxt;
    dot_r     <= dot_nxt;
    est_r     <= est_nxt;
    err_r     <= err_nxt;
    p_r       <= p_nxt;
    q_r       <= q_nxt;
    s_r       <= s_nxt;
    y_r       <= y_nxt;
    a_r       <= a_nxt;
    tmp_r     <= tmp_nxt;
    w_r       <= w_nxt;
    t1_r      <= t1_nxt;
    out_est_r <= out_est_nxt;
    out_err_r <= out_err_nxt;
  end

endmodule

// ===== sv/svdpp_chk.sv =====
// Port-level checker for the SVD++ factor engine, bound to the top level.
module svdpp_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // A command transfer always makes the engine busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("engine not busy after a command transfer");

  // A result is shown for a single cycle only.
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // The result appears when the engine has just become free.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result while busy or without a preceding command");

endmodule

bind svdpp_factor_sgd_engine svdpp_chk u_svdpp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

// ===== tb/svdpp_factor_sgd_engine_test.sv =====
// Self-checking testbench of the SVD++ factor engine with its own fixed-point predictor.
module svdpp_factor_sgd_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import svdpp_pkg::*;

  localparam int USERS     = 1024;
  localparam int ITEMS     = 1024;
  localparam int NF        = 32;
  localparam int STALL_MAX = 200000;  // covers the clearing sweep after reset and the longest train

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_command = CMD_PREDICT;
  logic [9:0]  in_user_index = '0;
  logic [9:0]  in_item_index = '0;
  logic [2:0]  in_rating = '0;
  logic [15:0] in_implicit_count = 16'd1;
  logic [15:0] in_explicit_count = '0;
  logic [5:0]  in_factor_slot = '0;
  logic signed [31:0] in_load_value = '0;
  logic        out_valid;
  logic signed [31:0] out_estimate;
  logic signed [31:0] out_error;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = REG_MEAN;
  logic [26:0] cfg_wdata = '0;

  svdpp_factor_sgd_engine u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_user_index(in_user_index),
    .in_item_index(in_item_index), .in_rating(in_rating),
    .in_implicit_count(in_implicit_count), .in_explicit_count(in_explicit_count),
    .in_factor_slot(in_factor_slot), .in_load_value(in_load_value),
    .out_valid(out_valid), .out_estimate(out_estimate), .out_error(out_error),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // One command as it is offered to the block.
  typedef struct {
    logic [2:0]  cmd;
    logic [9:0]  user;
    logic [9:0]  item;
    logic [2:0]  rating;
    logic [15:0] icount;
    logic [15:0] ecount;
    logic [5:0]  slot;
    logic [31:0] load;
  } command_t;

  // One expected result. The estimate is only compared once both addressed factor rows
  // have been written in full; before that the block reads memory that holds no value yet.
  typedef struct {
    logic [31:0] estimate;
    logic [31:0] error;
    bit          estimate_known;
  } rating_result_t;

  // Directed row: the command plus, where it is plain to see, its result typed in.
  typedef struct {
    command_t       c;
    bit             typed;
    rating_result_t r;
  } directed_row_t;

  rating_result_t pending_results[$];
  int  mismatches = 0;
  int  stall_cycles = 0;
  bit  gaps_on = 1'b1;

  // Predictor state: configuration and all tables, in Q8.24 held as 32-bit words.
  longint cfg_mean, cfg_brate, cfg_bdecay, cfg_frate, cfg_fdecay, cfg_irate, cfg_idecay;
  int     user_bias_m [USERS];
  int     item_bias_m [ITEMS];
  int     user_fac_m  [USERS][NF];
  int     item_fac_m  [ITEMS][NF];
  int     impl_fac_m  [ITEMS][NF];
  int     impl_sum_m  [USERS][NF];
  int     err_acc_m   [NF];
  bit [NF-1:0] user_written [USERS];
  bit [NF-1:0] item_written [ITEMS];

  // Users and items that are set up with full factor rows; all traffic stays on them.
  int user_pool [6] = '{0, 1023, 341, 682, 17, 900};
  int item_pool [6] = '{0, 1023, 341, 682, 17, 900};

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Product rounded half up to 24 fraction bits; the arithmetic shift floors.
  function automatic longint qmul(longint a, longint b);
    longint x;
    x = a * b + 64'sd8388608;
    return x >>> 24;
  endfunction

  // Bitwise search for floor(2^24 / sqrt(n)); a count of zero counts as one.
  function automatic longint inv_root(logic [15:0] count);
    longint unsigned n, r, c;
    n = (count == 0) ? 64'd1 : 64'(count);
    r = 0;
    for (int b = 24; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c <= (64'd1 << 24) && c * c * n <= (64'd1 << 48)) r = c;
    end
    return longint'(r);
  endfunction

  task automatic reset_model();
    cfg_mean = 60557633;  cfg_brate = 117441;  cfg_bdecay = 83886;
    cfg_frate = 117441;   cfg_fdecay = 251658;
    cfg_irate = 117441;   cfg_idecay = 251658;
    for (int i = 0; i < USERS; i++) begin
      user_bias_m[i] = 0;
      item_bias_m[i] = 0;
      user_written[i] = '0;
      item_written[i] = '0;
      for (int l = 0; l < NF; l++) begin
        user_fac_m[i][l] = 0;
        item_fac_m[i][l] = 0;
        impl_fac_m[i][l] = 0;
        impl_sum_m[i][l] = 0;
      end
    end
    for (int l = 0; l < NF; l++) err_acc_m[l] = 0;
  endtask

  // Forms the estimate from the state as it stands, then applies the command.
  function automatic rating_result_t rate_and_learn(command_t c);
    rating_result_t res;
    longint dot, est, err, inv, bu, bi, p, q, g, w, y;
    int u, m;
    u = int'(c.user);
    m = int'(c.item);
    dot = 0;
    for (int l = 0; l < NF; l++)
      dot += qmul(clamp32(longint'(user_fac_m[u][l]) + impl_sum_m[u][l]), item_fac_m[m][l]);
    est = clamp32(cfg_mean + user_bias_m[u] + item_bias_m[m] + dot);
    inv = inv_root(c.icount);
    err = 0;
    res.estimate_known = (&user_written[u]) && (&item_written[m]);
    case (c.cmd)
      CMD_BEGIN: begin
        for (int l = 0; l < NF; l++) begin
          impl_sum_m[u][l] = 0;
          err_acc_m[l] = 0;
        end
      end
      CMD_IMPLICIT: begin
        for (int l = 0; l < NF; l++)
          impl_sum_m[u][l] = int'(clamp32(impl_sum_m[u][l] + qmul(impl_fac_m[m][l], inv)));
      end
      CMD_TRAIN: begin
        err = clamp32(longint'(c.rating) * 16777216 - est);
        bu = user_bias_m[u];
        bi = item_bias_m[m];
        bu = clamp32(bu + qmul(cfg_brate, clamp32(err - qmul(cfg_bdecay, bu))));
        bi = clamp32(bi + qmul(cfg_brate, clamp32(err - qmul(cfg_bdecay, bi))));
        user_bias_m[u] = int'(bu);
        item_bias_m[m] = int'(bi);
        // The item update sees the user factor already updated in this step.
        for (int l = 0; l < NF; l++) begin
          p = user_fac_m[u][l];
          q = item_fac_m[m][l];
          g = clamp32(qmul(err, q) - qmul(cfg_fdecay, p));
          p = clamp32(p + qmul(cfg_frate, g));
          g = clamp32(qmul(err, clamp32(p + impl_sum_m[u][l])) - qmul(cfg_fdecay, q));
          q = clamp32(q + qmul(cfg_frate, g));
          user_fac_m[u][l] = int'(p);
          item_fac_m[m][l] = int'(q);
          err_acc_m[l] = int'(clamp32(err_acc_m[l] + qmul(qmul(err, q), inv)));
        end
      end
      CMD_UPDATE: begin
        w = clamp32(cfg_idecay * longint'(c.ecount));
        for (int l = 0; l < NF; l++) begin
          y = impl_fac_m[m][l];
          g = clamp32(err_acc_m[l] - qmul(w, y));
          impl_fac_m[m][l] = int'(clamp32(y + qmul(cfg_irate, g)));
        end
      end
      CMD_LOAD_U: begin
        if (c.slot < NF) begin
          user_fac_m[u][c.slot] = int'($signed(c.load));
          user_written[u][c.slot] = 1'b1;
        end
      end
      CMD_LOAD_I: begin
        if (c.slot < NF) begin
          item_fac_m[m][c.slot] = int'($signed(c.load));
          item_written[m][c.slot] = 1'b1;
        end
      end
      default: ;  // predict and the spare code only report the estimate
    endcase
    res.estimate = est[31:0];
    res.error = err[31:0];
    return res;
  endfunction

  // Offers one command and waits for the transfer. The expected result is worked out at the
  // accepting edge, since the block runs one command at a time in order.
  task automatic issue(command_t c, bit typed = 1'b0, rating_result_t typed_res = '{0, 0, 0});
    rating_result_t res;
    if (gaps_on && $urandom_range(99) < 29) repeat ($urandom_range(1, 6)) @(posedge clk);
    @(posedge clk);
    start <= 1'b1;
    in_command <= c.cmd;
    in_user_index <= c.user;
    in_item_index <= c.item;
    in_rating <= c.rating;
    in_implicit_count <= c.icount;
    in_explicit_count <= c.ecount;
    in_factor_slot <= c.slot;
    in_load_value <= c.load;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    res = rate_and_learn(c);
    if (typed) res = typed_res;
    pending_results = {pending_results, res};
  endtask

  task automatic write_reg(logic [2:0] idx, longint value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[26:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_MEAN:   cfg_mean   = value & 64'h7FFFFFF;
      REG_BRATE:  cfg_brate  = value & 64'hFFFFFF;
      REG_BDECAY: cfg_bdecay = value & 64'hFFFFFF;
      REG_FRATE:  cfg_frate  = value & 64'hFFFFFF;
      REG_FDECAY: cfg_fdecay = value & 64'hFFFFFF;
      REG_IRATE:  cfg_irate  = value & 64'hFFFFFF;
      REG_IDECAY: cfg_idecay = value & 64'hFFFFFF;
      default: ;  // index out of range is dropped by the block
    endcase
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_all(longint mean, longint rates, longint decays);
    write_reg(REG_MEAN, mean);
    write_reg(REG_BRATE, rates);
    write_reg(REG_BDECAY, decays);
    write_reg(REG_FRATE, rates);
    write_reg(REG_FDECAY, decays);
    write_reg(REG_IRATE, rates);
    write_reg(REG_IDECAY, decays);
  endtask

  function automatic command_t make_cmd(logic [2:0] cmd, int user, int item);
    command_t c;
    c.cmd = cmd;
    c.user = 10'(user);
    c.item = 10'(item);
    c.rating = 3'($urandom_range(5));
    c.icount = ($urandom_range(9) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(1, 64));
    c.ecount = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    c.slot = ($urandom_range(9) == 0) ? 6'($urandom_range(NF, 63)) : 6'($urandom_range(NF - 1));
    // Mostly factors within about plus or minus two, now and then any 32-bit pattern.
    c.load = ($urandom_range(4) == 0) ? 32'($urandom)
                                      : 32'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
    return c;
  endfunction

  // A well-formed round for one user: reset its implicit sum, gather implicit items, train
  // on ratings and push the accumulated error into the implicit factors. A few random
  // commands are mixed in as noise.
  task automatic user_round(output int sent);
    command_t c;
    int u, n;
    u = user_pool[$urandom_range(5)];
    n = $urandom_range(2, 5);
    sent = 0;
    issue(make_cmd(CMD_BEGIN, u, item_pool[$urandom_range(5)]));
    sent++;
    for (int k = 0; k < n; k++) begin
      issue(make_cmd(CMD_IMPLICIT, u, item_pool[$urandom_range(5)]));
      sent++;
    end
    for (int k = 0; k < n; k++) begin
      c = make_cmd(CMD_TRAIN, u, item_pool[$urandom_range(5)]);
      if ($urandom_range(9) == 0) c.cmd = 3'($urandom_range(7));
      issue(c);
      sent++;
    end
    for (int k = 0; k < n / 2 + 1; k++) begin
      issue(make_cmd(CMD_UPDATE, u, item_pool[$urandom_range(5)]));
      sent++;
    end
  endtask

  task automatic random_phase(int count);
    int sent, done;
    done = 0;
    while (done < count) begin
      // A stretch in the middle of each phase runs with no gaps at all.
      gaps_on = !(done > count / 3 && done < count / 2);
      if ($urandom_range(3) == 0) begin
        issue(make_cmd(3'($urandom_range(7)), user_pool[$urandom_range(5)],
                       item_pool[$urandom_range(5)]));
        done++;
      end else begin
        user_round(sent);
        done += sent;
      end
    end
    gaps_on = 1'b1;
  endtask

  // Result side: every strobe is compared with the oldest expectation.
  always @(posedge clk) begin
    rating_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: estimate %0d error %0d", out_estimate, out_error);
      end else begin
        want = pending_results.pop_front();
        if ((want.estimate_known && out_estimate !== want.estimate) ||
            out_error !== want.error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: estimate %0d/%0d error %0d/%0d (expected/actual)",
                     $signed(want.estimate), out_estimate, $signed(want.error), out_error);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither side makes a transfer.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    directed_row_t rows [15];
    command_t c;
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults are rewritten once so every register sees a write; the block takes
    // them during its clearing sweep.
    write_all(60557633, 117441, 83886);
    write_reg(REG_FDECAY, 251658);
    write_reg(REG_IDECAY, 251658);

    // Fill the factor rows of the pool with zeros. Until a row pair is complete the
    // estimate of a load is not checked.
    foreach (user_pool[k])
      for (int l = 0; l < NF; l++) begin
        c = make_cmd(CMD_LOAD_U, user_pool[k], user_pool[0]);
        c.slot = 6'(l);
        c.load = '0;
        issue(c);
      end
    foreach (item_pool[k])
      for (int l = 0; l < NF; l++) begin
        c = make_cmd(CMD_LOAD_I, user_pool[0], item_pool[k]);
        c.slot = 6'(l);
        c.load = '0;
        issue(c);
      end

    // Directed rows. With zero factors and biases the first results follow from the mean.
    rows[0]  = '{make_cmd(CMD_PREDICT, 0, 0), 1, '{32'd60557633, 32'd0, 1}};
    rows[1]  = '{make_cmd(CMD_TRAIN, 1023, 1023), 1, '{32'd60557633, 32'd23328447, 1}};
    rows[1].c.rating = 3'd5;
    rows[2]  = '{make_cmd(CMD_TRAIN, 341, 341), 1, '{32'd60557633, -32'sd60557633, 1}};
    rows[2].c.rating = 3'd0;
    rows[3]  = '{make_cmd(CMD_LOAD_U, 0, 0), 0, '{0, 0, 0}};
    rows[3].c.slot = 6'd0;
    rows[3].c.load = 32'h7FFFFFFF;
    rows[4]  = '{make_cmd(CMD_LOAD_I, 0, 0), 0, '{0, 0, 0}};
    rows[4].c.slot = 6'd0;
    rows[4].c.load = 32'h80000000;
    rows[5]  = '{make_cmd(CMD_PREDICT, 0, 0), 0, '{0, 0, 0}};
    rows[6]  = '{make_cmd(CMD_LOAD_U, 0, 0), 0, '{0, 0, 0}};
    rows[6].c.slot = 6'd63;  // slot past the last factor: nothing changes
    rows[7]  = '{make_cmd(CMD_LOAD_U, 0, 0), 0, '{0, 0, 0}};
    rows[7].c.slot = 6'd0;
    rows[7].c.load = 32'h01000000;
    rows[8]  = '{make_cmd(CMD_BEGIN, 0, 0), 0, '{0, 0, 0}};
    rows[9]  = '{make_cmd(CMD_IMPLICIT, 0, 0), 0, '{0, 0, 0}};
    rows[9].c.icount = 16'd0;  // zero count acts as one
    rows[10] = '{make_cmd(CMD_TRAIN, 0, 0), 0, '{0, 0, 0}};
    rows[10].c.icount = 16'hFFFF;
    rows[11] = '{make_cmd(CMD_UPDATE, 0, 0), 0, '{0, 0, 0}};
    rows[11].c.ecount = 16'hFFFF;
    rows[12] = '{make_cmd(CMD_SPARE, 682, 682), 0, '{0, 0, 0}};  // acts as predict
    rows[13] = '{make_cmd(CMD_TRAIN, 0, 1023), 0, '{0, 0, 0}};
    rows[13].c.rating = 3'd4;
    rows[14] = '{make_cmd(CMD_PREDICT, 1023, 0), 0, '{0, 0, 0}};
    foreach (rows[k]) issue(rows[k].c, rows[k].typed, rows[k].r);

    // Random phases under changing configuration, written only once the block is idle.
    random_phase(140);
    drain();
    write_all(0, 0, 0);
    write_reg(REG_NONE, 27'h5A5A5A5);
    random_phase(130);
    drain();
    write_all(100663296, 16777215, 16777215);
    random_phase(130);
    drain();
    write_all($urandom_range(100663296), $urandom_range(16777215), $urandom_range(1 << 20));
    random_phase(130);
    drain();
    write_all(60557633, 117441, 83886);
    random_phase(120);

    drain();
    repeat (700) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
